// ===== sv/qebs_pkg.sv =====
// shared types and constants of the quantized embedding-bag block
`timescale 1ns / 1ps
`default_nettype none
package qebs_pkg;

	localparam int VALUE_W = 48;
	localparam int COUNT_W = 16;

	localparam logic signed [VALUE_W-1:0] ACC_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] ACC_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [23:0] WEIGHT_ONE = 24'sd65536;

	typedef enum logic [1:0] {
		CFG_ELEMS      = 2'd0,
		CFG_ROWS       = 2'd1,
		CFG_NORMALIZE  = 2'd2,
		CFG_WEIGHTS    = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		OP_WRITE_BYTE = 2'd0,
		OP_WRITE_ROW  = 2'd1,
		OP_LOOKUP     = 2'd2,
		OP_EMPTY      = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         row;
		logic [5:0]         column;
		logic [7:0]         data_byte;
		logic signed [31:0] row_scale;
		logic signed [31:0] row_bias;
		logic signed [31:0] lookup_index;
		logic signed [23:0] weight;
		logic               last_in_segment;
	} in_word_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic [5:0]         element_index;
		logic               last_element;
		logic               status;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_CAP,
		ST_DIV_WAIT,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic cnt_clr;
		logic cnt_inc;
		logic emit_rd;
		logic emit_cap;
		logic div_start;
		logic div_cap;
		logic out_load;
		logic seg_clear;
	} cmd_t;

	typedef struct packed {
		logic lookup_ok;
		logic elem_last;
		logic pipe_busy;
		logic use_div;
		logic div_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/qebs_divider.sv =====
// serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none
module qebs_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [qebs_pkg::VALUE_W-1:0]  dividend,
	input  logic [qebs_pkg::COUNT_W-1:0]         divisor,
	output logic                                 done,
	output logic signed [qebs_pkg::VALUE_W-1:0]  quotient
);
	import qebs_pkg::*;

	localparam int CNT_W = $clog2(VALUE_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0] rem_q;
	logic [VALUE_W-1:0] quo_q;
	logic [COUNT_W-1:0] div_q;
	logic               neg_q;

	logic [COUNT_W:0]   rem_sh;
	logic [COUNT_W:0]   diff;

	assign rem_sh = {rem_q, quo_q[VALUE_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[VALUE_W-1];
			quo_q <= dividend[VALUE_W-1] ? VALUE_W'(-dividend) : VALUE_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// restoring step: keep the difference when no borrow
			if (!diff[COUNT_W]) begin
				rem_q <= diff[COUNT_W-1:0];
				quo_q <= {quo_q[VALUE_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[COUNT_W-1:0];
				quo_q <= {quo_q[VALUE_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

// ===== sv/qebs_datapath.sv =====
// table memories, accumulate pipeline, accumulator row, divider and output register
`timescale 1ns / 1ps
`default_nettype none
module qebs_datapath #(
	parameter int TABLE_ROWS       = 1024,
	parameter int MAX_ROW_ELEMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qebs_pkg::in_word_t  in_word,
	input  qebs_pkg::cmd_t      cmd,
	input  logic [6:0]          elems_cfg,
	input  logic [10:0]         rows,
	input  logic                normalize,
	input  logic                weights_on,
	input  logic                out_stall,
	output logic                out_valid,
	output qebs_pkg::out_word_t out_word,
	output qebs_pkg::status_t   sts
);
	import qebs_pkg::*;

	localparam int ROW_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int CW    = (MAX_ROW_ELEMENTS > 1) ? $clog2(MAX_ROW_ELEMENTS) : 1;
	localparam int NW    = $clog2(MAX_ROW_ELEMENTS + 1);
	localparam int TDEPTH = TABLE_ROWS * MAX_ROW_ELEMENTS;
	localparam int TAW   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	logic [7:0]               tbl_mem [TDEPTH];
	logic signed [31:0]       scale_mem [TABLE_ROWS];
	logic signed [31:0]       bias_mem [TABLE_ROWS];
	logic signed [VALUE_W-1:0] acc_mem [MAX_ROW_ELEMENTS];
	logic [MAX_ROW_ELEMENTS-1:0] acc_vld_q;

	logic [NW-1:0]            n_elems;
	logic [NW-1:0]            j_q;
	logic [NW:0]              j_next;
	logic [31:0]              limit;
	logic [31:0]              row32;
	logic [31:0]              wr_addr;
	logic [31:0]              rd_base;
	logic [31:0]              j32;

	logic [TAW-1:0]           base_q;
	logic signed [31:0]       scale_q;
	logic signed [31:0]       bias_q;
	logic signed [23:0]       w_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic                     err_q;

	logic                     v_s1, v_s2, v_s3;
	logic [CW-1:0]            j_s1, j_s2, j_s3;
	logic [7:0]               byte_s1;
	logic signed [40:0]       p_s2;
	logic signed [64:0]       prod_s3;
	logic signed [40:0]       p_w;
	logic signed [64:0]       prod_w;
	logic signed [VALUE_W-1:0] term_w;
	logic signed [VALUE_W:0]  sum_w;
	logic signed [VALUE_W-1:0] sat_w;

	logic [CW-1:0]            acc_addr;
	logic signed [VALUE_W-1:0] acc_rd_q;
	logic                     acc_rd_vld_q;
	logic signed [VALUE_W-1:0] acc_cur;

	logic signed [VALUE_W-1:0] emit_val_q;
	logic                     div_done;
	logic signed [VALUE_W-1:0] div_quo;
	logic                     out_valid_q;
	out_word_t                out_q;

	always_comb begin
		if (elems_cfg == '0)
			n_elems = NW'(1);
		else if (int'(elems_cfg) > MAX_ROW_ELEMENTS)
			n_elems = NW'(MAX_ROW_ELEMENTS);
		else
			n_elems = NW'(elems_cfg);
	end

	assign j_next = {1'b0, j_q} + 1'b1;
	assign j32    = 32'(j_q);
	assign limit  = (int'(rows) > TABLE_ROWS) ? 32'(TABLE_ROWS) : 32'(rows);
	assign row32  = 32'(in_word.row);
	assign wr_addr = row32 * 32'(MAX_ROW_ELEMENTS) + 32'(in_word.column);
	assign rd_base = 32'(in_word.lookup_index) * 32'(MAX_ROW_ELEMENTS);

	assign sts.lookup_ok = !in_word.lookup_index[31] && (32'(in_word.lookup_index) < limit);
	assign sts.elem_last = (j_next == (NW + 1)'(n_elems));
	assign sts.pipe_busy = v_s1 | v_s2 | v_s3;
	assign sts.use_div   = normalize && (cnt_q != '0);
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// table and row parameter writes, and table byte and row parameter reads
	always_ff @(posedge clk) begin
		if (cmd.accept && in_word.op == OP_WRITE_BYTE && row32 < 32'(TABLE_ROWS)
		    && 32'(in_word.column) < 32'(MAX_ROW_ELEMENTS))
			tbl_mem[wr_addr[TAW-1:0]] <= in_word.data_byte;
		if (cmd.issue)
			byte_s1 <= tbl_mem[base_q + TAW'(j_q[CW-1:0])];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_word.op == OP_WRITE_ROW && row32 < 32'(TABLE_ROWS)) begin
			scale_mem[row32[ROW_W-1:0]] <= in_word.row_scale;
			bias_mem[row32[ROW_W-1:0]]  <= in_word.row_bias;
		end else if (cmd.accept && in_word.op == OP_LOOKUP) begin
			scale_q <= scale_mem[in_word.lookup_index[ROW_W-1:0]];
			bias_q  <= bias_mem[in_word.lookup_index[ROW_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_word.op == OP_LOOKUP) begin
			base_q <= rd_base[TAW-1:0];
			w_q    <= weights_on ? in_word.weight : WEIGHT_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
			j_q   <= '0;
		end else begin
			if (cmd.seg_clear) begin
				cnt_q <= '0;
				err_q <= 1'b0;
			end else if (cmd.accept && in_word.op == OP_LOOKUP) begin
				if (cnt_q != '1)
					cnt_q <= cnt_q + 1'b1;
				if (!sts.lookup_ok)
					err_q <= 1'b1;
			end
			if (cmd.cnt_clr)
				j_q <= '0;
			else if (cmd.cnt_inc)
				j_q <= j_next[NW-1:0];
		end
	end

	// accumulate pipeline
	assign p_w    = scale_q * $signed({1'b0, byte_s1}) + bias_q;
	assign prod_w = p_s2 * w_q;
	assign term_w = $signed(prod_s3[63:16]);
	assign acc_cur = acc_rd_vld_q ? acc_rd_q : '0;
	assign sum_w  = acc_cur + term_w;
	assign sat_w  = (sum_w[VALUE_W] != sum_w[VALUE_W-1]) ?
		(sum_w[VALUE_W] ? ACC_MIN : ACC_MAX) : sum_w[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		j_s1    <= j_q[CW-1:0];
		j_s2    <= j_s1;
		j_s3    <= j_s2;
		p_s2    <= p_w;
		prod_s3 <= prod_w;
	end

	assign acc_addr = cmd.emit_rd ? j_q[CW-1:0] : j_s2;

	always_ff @(posedge clk) begin
		acc_rd_q <= acc_mem[acc_addr];
		if (v_s3)
			acc_mem[j_s3] <= sat_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q    <= '0;
			acc_rd_vld_q <= 1'b0;
		end else begin
			acc_rd_vld_q <= acc_vld_q[acc_addr];
			if (cmd.seg_clear)
				acc_vld_q <= '0;
			else if (v_s3)
				acc_vld_q[j_s3] <= 1'b1;
		end
	end

	qebs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_cur),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit_cap)
			emit_val_q <= acc_cur;
		else if (cmd.div_cap)
			emit_val_q <= div_quo;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.value         <= emit_val_q;
			out_q.element_index <= j32[5:0];
			out_q.last_element  <= sts.elem_last;
			out_q.status        <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire

// ===== sv/qebs_ctrl.sv =====
// sequencer for load, lookup and segment emit
`timescale 1ns / 1ps
`default_nettype none
module qebs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qebs_pkg::op_t     in_op,
	input  logic              in_last,
	input  qebs_pkg::status_t sts,
	output logic              in_stall,
	output qebs_pkg::cmd_t    cmd
);
	import qebs_pkg::*;

	state_t state_q, state_d;
	logic   last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		last_d   = last_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					last_d     = in_last;
					case (in_op)
						OP_LOOKUP: begin
							cmd.cnt_clr = 1'b1;
							if (sts.lookup_ok)
								state_d = ST_ACCUM;
							else if (in_last)
								state_d = ST_EMIT_RD;
						end
						OP_EMPTY: begin
							cmd.cnt_clr = 1'b1;
							state_d     = ST_EMIT_RD;
						end
						default: ;
					endcase
				end
			end
			ST_ACCUM: begin
				cmd.issue   = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.elem_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.cnt_clr = 1'b1;
					state_d     = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_CAP;
			end
			ST_EMIT_CAP: begin
				cmd.emit_cap = 1'b1;
				if (sts.use_div) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_WAIT;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_cap = 1'b1;
					state_d     = ST_PUT;
				end
			end
			ST_PUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.elem_last) begin
						cmd.seg_clear = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = ST_EMIT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/quantized_embedding_bag_sum.sv =====
// top level of the quantized embedding-bag sum block
`timescale 1ns / 1ps
`default_nettype none
// Embedding-bag sum over an 8-bit row-quantized table held in on-chip memory.
// Items are taken one at a time. A lookup of an in-range row streams the row from
// table memory one element per cycle through a three-stage multiply/accumulate
// pipeline. A segment end emits one word per element, each word passing through
// the serial divider (one quotient bit per cycle) when mean normalization divides
// by a nonzero lookup count, and waits while the output side stalls. The
// accumulator row clears through per-element valid bits, so no clearing pass runs
// after reset.
module quantized_embedding_bag_sum #(
	parameter int TABLE_ROWS       = 1024,
	parameter int MAX_ROW_ELEMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qebs_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output qebs_pkg::out_word_t out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  qebs_pkg::cfg_index_t cfg_index,
	input  logic [31:0]         cfg_data
);
	import qebs_pkg::*;

	logic [6:0]  elems_cfg_q;
	logic [10:0] rows_q;
	logic        normalize_q;
	logic        weights_q;
	cmd_t        cmd;
	status_t     sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elems_cfg_q  <= 7'd64;
			rows_q       <= 11'd1024;
			normalize_q  <= 1'b0;
			weights_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ELEMS:      elems_cfg_q  <= cfg_data[6:0];
				CFG_ROWS:       rows_q       <= cfg_data[10:0];
				CFG_NORMALIZE:  normalize_q  <= cfg_data[0];
				CFG_WEIGHTS:    weights_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	qebs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_word.op),
		.in_last  (in_word.last_in_segment),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	qebs_datapath #(
		.TABLE_ROWS       (TABLE_ROWS),
		.MAX_ROW_ELEMENTS (MAX_ROW_ELEMENTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_word    (in_word),
		.cmd        (cmd),
		.elems_cfg  (elems_cfg_q),
		.rows       (rows_q),
		.normalize  (normalize_q),
		.weights_on (weights_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_word   (out_word),
		.sts        (sts)
	);

	// a pending output word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output word overwritten");

	// accumulate pipeline is empty whenever a new item may enter
	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.pipe_busy)
		else $error("pipeline busy while accepting");

	// segment state clears only with the final element word
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_clear |=> (out_valid && out_word.last_element))
		else $error("segment cleared without final element");

endmodule
`default_nettype wire
